@@ design/rmq_pkg.sv @@
// shared constants and types for the matrix to quaternion pipeline
`default_nettype none
package rmq_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W = 16;
  // radicand width: three inputs plus one, with a sign
  localparam int RAD_W = IN_W + 3;
  // numerator width: sum or difference of two inputs
  localparam int NUM_W = IN_W + 1;
  // half root width
  localparam int ROOT_W = 18;
  // saturated quotient cap
  localparam int QCAP_W = 41;
  localparam logic signed [IN_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [IN_W-1:0] OUT_MIN = -16'sh8000;

  typedef enum logic [1:0] {
    SEL_TRACE = 2'd0,
    SEL_DX    = 2'd1,
    SEL_DY    = 2'd2,
    SEL_DZ    = 2'd3
  } branch_t;
endpackage
`default_nettype wire

@@ design/rotation_matrix_to_quaternion.sv @@
// top level: rotation matrix to quaternion, fully pipelined
`default_nettype none
// usage
//   a request is the nine matrix elements m00..m22 in signed Q2.14 (FRAC_BITS
//   fraction bits). it is taken at a rising edge with start high and busy low.
//   busy is tied low: the pipeline takes one request every cycle.
//   each result (q_w, q_x, q_y, q_z, degenerate) is on its ports for one
//   cycle with done high; the receiver cannot stall, none is needed.
// pipeline
//   stage 1 picks the branch (trace or largest diagonal), forms the radicand
//   and the three numerators.
//   then a square root of r*2^(F-2), one root bit per stage (F+2 stages).
//   then a restoring divider, one quotient bit per stage, for each of the
//   three numerators in parallel lanes, plus a saturation register.
//   then an output register that orders the four components by branch.
//   throughput is one request per cycle.
// reset
//   rst clears the valid bits of every stage; data registers are not reset.
// degenerate
//   a non-positive radicand gives degenerate high and zero components.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [15:0] m00, m01, m02,
  input  wire logic signed [15:0] m10, m11, m12,
  input  wire logic signed [15:0] m20, m21, m22,
  output logic             done,
  output logic signed [15:0] q_w, q_x, q_y, q_z,
  output logic             degenerate
);
  localparam int RADW = FRAC_BITS + 5;
  // root argument r << (F-2), r below 2^(F+3)
  localparam int SW = (2*FRAC_BITS + 2) / 2 + 1;
  localparam int VW = 2 * SW;
  // tag: degen, branch, three numerators
  localparam int NW = rmq_pkg::NUM_W;
  localparam int TW = 3 + 3*NW;

  logic signed [15:0] mat [9];
  logic f_v, f_dg;
  logic signed [RADW-1:0] f_rad;
  rmq_pkg::branch_t f_br;
  logic signed [NW-1:0] f_num [3];
  logic [VW-1:0] sq_val;
  logic s_v;
  logic [SW-1:0] s_root;
  logic [TW-1:0] s_tag, s_tag_in;
  logic [2:0] d_v;
  logic signed [15:0] d_q [3];
  logic [TW-1:0] d_tag [3];
  logic [15:0] hq;
  logic o_dg;
  rmq_pkg::branch_t o_br;
  logic vld_pipe;

  assign busy = 1'b0;
  assign mat = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start & ~rst), .mat(mat), .out_valid(f_v),
    .rad(f_rad), .degen(f_dg), .branch(f_br), .num(f_num)
  );

  // degenerate radicand feeds zero into the root
  assign sq_val = f_dg ? '0 : (VW'(unsigned'(f_rad)) << (FRAC_BITS - 2));
  assign s_tag_in = {f_dg, f_br, f_num[0], f_num[1], f_num[2]};

  rmq_sqrt #(.VW(VW), .SW(SW), .TW(TW)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(f_v & ~rst), .val(sq_val), .tag_in(s_tag_in),
    .out_valid(s_v), .root(s_root), .tag_out(s_tag)
  );

  for (genvar l = 0; l < 3; l++) begin : g_div
    rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(SW), .TW(TW)) u_div (
      .clk(clk), .rst(rst), .in_valid(s_v & ~rst),
      .num(s_tag[(2-l)*NW +: NW]),
      // a zero root only comes with degenerate; keep the divisor nonzero
      .h(s_root | SW'(s_tag[TW-1])),
      .tag_in(l == 0 ? {s_tag[TW-1:16], hq} : s_tag),
      .out_valid(d_v[l]), .q(d_q[l]), .tag_out(d_tag[l])
    );
  end

  // root saturated to 16 bits travels in lane zero's tag
  assign hq = (s_root > SW'(32767)) ? 16'h7fff : s_root[15:0];
  assign o_dg = d_tag[0][TW-1];
  assign o_br = rmq_pkg::branch_t'(d_tag[0][TW-2:TW-3]);
  assign vld_pipe = d_v[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_pipe;
    end
    degenerate <= o_dg;
    if (o_dg) begin
      q_w <= '0; q_x <= '0; q_y <= '0; q_z <= '0;
    end else begin
      case (o_br)
        rmq_pkg::SEL_TRACE: begin
          q_w <= d_tag[0][15:0]; q_x <= d_q[0]; q_y <= d_q[1]; q_z <= d_q[2];
        end
        rmq_pkg::SEL_DX: begin
          q_x <= d_tag[0][15:0]; q_w <= d_q[0]; q_y <= d_q[1]; q_z <= d_q[2];
        end
        rmq_pkg::SEL_DY: begin
          q_y <= d_tag[0][15:0]; q_w <= d_q[0]; q_z <= d_q[1]; q_x <= d_q[2];
        end
        default: begin
          q_z <= d_tag[0][15:0]; q_w <= d_q[0]; q_x <= d_q[1]; q_y <= d_q[2];
        end
      endcase
    end
  end

`ifndef SYNTH
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    d_v[0] == d_v[1] && d_v[1] == d_v[2]) else $error("divider lanes out of step");
  a_busy_low: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    vld_pipe |=> done) else $error("result lost");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> q_w == 0 && q_x == 0 && q_y == 0 && q_z == 0)
    else $error("degenerate result not zero");
`endif
endmodule
`default_nettype wire

@@ design/rmq_front.sv @@
// branch selection, radicand and numerator forming
`default_nettype none
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic signed [rmq_pkg::IN_W-1:0]  mat [9],
  output logic                                  out_valid,
  output logic signed [FRAC_BITS+4:0]           rad,
  output logic                                  degen,
  output rmq_pkg::branch_t                      branch,
  output logic signed [rmq_pkg::NUM_W-1:0]      num [3]
);
  localparam int RW = FRAC_BITS + 5;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint TH = (ONE + 50) / 100;

  logic signed [RW-1:0] tr, d0, d1, d2, rsel;
  logic signed [RW-1:0] a00, a11, a22;
  rmq_pkg::branch_t bsel;
  logic signed [rmq_pkg::NUM_W-1:0] n0, n1, n2;
  logic signed [rmq_pkg::NUM_W-1:0] e [9];

  always_comb begin
    for (int t = 0; t < 9; t++) e[t] = rmq_pkg::NUM_W'(mat[t]);
    a00 = RW'(mat[0]);
    a11 = RW'(mat[4]);
    a22 = RW'(mat[8]);
    tr = a00 + a11 + a22 + RW'(ONE);
    d0 = a00 - (a11 + a22) + RW'(ONE);
    d1 = a11 - (a22 + a00) + RW'(ONE);
    d2 = a22 - (a00 + a11) + RW'(ONE);
    if (tr > RW'(TH)) begin
      bsel = rmq_pkg::SEL_TRACE;
      rsel = tr;
      n0 = e[5] - e[7];
      n1 = e[6] - e[2];
      n2 = e[1] - e[3];
    end else if (mat[0] < mat[4] ? !(mat[4] < mat[8]) : !(mat[0] < mat[8])) begin
      if (mat[0] < mat[4]) begin
        bsel = rmq_pkg::SEL_DY;
        rsel = d1;
        n0 = e[6] - e[2];
        n1 = e[5] + e[7];
        n2 = e[3] + e[1];
      end else begin
        bsel = rmq_pkg::SEL_DX;
        rsel = d0;
        n0 = e[5] - e[7];
        n1 = e[1] + e[3];
        n2 = e[2] + e[6];
      end
    end else begin
      bsel = rmq_pkg::SEL_DZ;
      rsel = d2;
      n0 = e[1] - e[3];
      n1 = e[6] + e[2];
      n2 = e[7] + e[5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    rad <= rsel;
    degen <= (rsel <= 0);
    branch <= bsel;
    num[0] <= n0;
    num[1] <= n1;
    num[2] <= n2;
  end
endmodule
`default_nettype wire

@@ design/rmq_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none
module rmq_sqrt #(
  parameter int VW = 32,
  parameter int SW = 16,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [VW-1:0] val,
  input  wire logic [TW-1:0] tag_in,
  output logic               out_valid,
  output logic [SW-1:0]      root,
  output logic [TW-1:0]      tag_out
);
  // restoring digit recurrence, one digit per stage
  logic [SW:0]     vld;
  logic [2*SW-1:0] rem [SW+1];
  logic [SW-1:0]   res [SW+1];
  logic [TW-1:0]   tg  [SW+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = (2*SW)'(val);
    res[0] = '0;
    tg[0]  = tag_in;
  end

  for (genvar s = 0; s < SW; s++) begin : g_st
    logic [SW+1:0] part, trial;
    always_comb begin
      part  = (SW+2)'(rem[s] >> (2*(SW-1-s)));
      trial = {res[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      tg[s+1]  <= tg[s];
      if (part >= trial) begin
        rem[s+1] <= rem[s] - ((2*SW)'(trial) << (2*(SW-1-s)));
        res[s+1] <= {res[s][SW-2:0], 1'b1};
      end else begin
        rem[s+1] <= rem[s];
        res[s+1] <= {res[s][SW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[SW];
  assign root      = res[SW];
  assign tag_out   = tg[SW];
endmodule
`default_nettype wire

@@ design/rmq_div.sv @@
// pipelined rounded divider: num * 2^F / (4h), ties away from zero, saturated
`default_nettype none
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int DW = 20,
  parameter int TW = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic signed [rmq_pkg::NUM_W-1:0]  num,
  input  wire logic [DW-1:0]                     h,
  input  wire logic [TW-1:0]                     tag_in,
  output logic                                   out_valid,
  output logic signed [rmq_pkg::IN_W-1:0]        q,
  output logic [TW-1:0]                          tag_out
);
  // dividend is 2*mag*2^F + 4h, divisor 8h: floor gives round half up
  localparam int NW = rmq_pkg::NUM_W + FRAC_BITS + 1;
  localparam int QB = NW;
  localparam int RW = DW + 4;

  logic [QB:0]     vld;
  logic [NW-1:0]   dvd [QB+1];
  logic [RW-1:0]   rem [QB+1];
  logic [NW-1:0]   quo [QB+1];
  logic [DW+2:0]   dvs [QB+1];
  logic [QB:0]     neg;
  logic [TW-1:0]   tg  [QB+1];
  logic [rmq_pkg::NUM_W-1:0] mag;

  always_comb begin
    mag = num[rmq_pkg::NUM_W-1] ? rmq_pkg::NUM_W'(-num) : rmq_pkg::NUM_W'(num);
    vld[0] = in_valid;
    dvd[0] = (NW'(mag) << (FRAC_BITS + 1)) + NW'({h, 2'b00});
    rem[0] = '0;
    quo[0] = '0;
    dvs[0] = {h, 3'b000};
    neg[0] = num[rmq_pkg::NUM_W-1];
    tg[0]  = tag_in;
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    logic [RW-1:0] sh;
    always_comb sh = {rem[s][RW-2:0], dvd[s][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      neg[s+1] <= neg[s];
      tg[s+1]  <= tg[s];
      dvs[s+1] <= dvs[s];
      dvd[s+1] <= {dvd[s][NW-2:0], 1'b0};
      if (sh >= RW'(dvs[s])) begin
        rem[s+1] <= sh - RW'(dvs[s]);
        quo[s+1] <= {quo[s][NW-2:0], 1'b1};
      end else begin
        rem[s+1] <= sh;
        quo[s+1] <= {quo[s][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[QB];
    end
    tag_out   <= tg[QB];
    if (neg[QB]) begin
      q <= (quo[QB] > NW'(32768)) ? rmq_pkg::OUT_MIN
         : rmq_pkg::IN_W'(-$signed({1'b0, quo[QB]}));
    end else begin
      q <= (quo[QB] > NW'(32767)) ? rmq_pkg::OUT_MAX : rmq_pkg::IN_W'(quo[QB]);
    end
  end
endmodule
`default_nettype wire
